[rtl/skubs_pkg.sv]
// ----------------------------------------------------------------------------
// skubs_pkg
// Shared widths, defaults and action codes for the sorted-key search block.
// ----------------------------------------------------------------------------
package skubs_pkg;

  localparam int unsigned StoreDepthDefault = 16384;

  localparam int unsigned KeyW = 64;  // stored and searched key
  localparam int unsigned IdxW = 14;  // write index and range low
  localparam int unsigned PosW = 15;  // range high and result positions

  typedef enum logic {
    ActWrite = 1'b0,
    ActQuery = 1'b1
  } action_e;

endpackage

[rtl/sorted_key_upper_bound_search.sv]
// ----------------------------------------------------------------------------
// sorted_key_upper_bound_search
// Binary search with early exit and duplicate scan over a key memory.
// ----------------------------------------------------------------------------
// Usage:
// One input channel (in_valid_i / in_ready_o) carries two kinds of transaction.
// A write transaction (action = write) stores key_value_i at write_index_i and
// gives no result. A query transaction searches the
// inclusive range [range_low_i, range_high_i] for key_value_i and gives one
// result on the output channel (out_valid_o / out_ready_i): match flag, match
// or last-smaller position, and the upper bound.
// A query runs binary search probes (at most 15 at depth 16384); on a match
// it scans past the duplicate keys, up to range_high, then loads the result
// register. Each probe and each scan step first reads the key memory
// (synchronous read) and then compares the returned key. Writes sustain one
// per cycle while no query is in progress.
// Reset clears the control state and the result valid flag only; the key
// memory holds garbage until written, and queries must touch only written
// entries.
// A stalled receiver holds the result register; the block still accepts the
// next transaction and works on it, and a finished query waits for the
// register to drain before loading.
// ----------------------------------------------------------------------------
module sorted_key_upper_bound_search #(
  parameter int unsigned STORE_DEPTH = skubs_pkg::StoreDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [skubs_pkg::IdxW-1:0]          write_index_i,
  input  logic signed [skubs_pkg::KeyW-1:0]   key_value_i,
  input  logic [skubs_pkg::IdxW-1:0]          range_low_i,
  input  logic signed [skubs_pkg::PosW-1:0]   range_high_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                match_found_o,
  output logic signed [skubs_pkg::PosW-1:0]   match_position_o,
  output logic [skubs_pkg::PosW-1:0]          upper_bound_position_o
);
  import skubs_pkg::*;

  localparam int unsigned AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  // Internal positions: signed, one bit wider than the port so that
  // lo can reach range_high + 1 and hi can drop to range_low - 1.
  localparam int unsigned IntW = PosW + 1;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StProbe,
    StScan,
    StScanCmp,
    StDone
  } state_e;

  typedef logic signed [IntW-1:0] ipos_t;

  // Key memory, no reset.
  logic signed [KeyW-1:0] mem_q [STORE_DEPTH];
  logic signed [KeyW-1:0] rdata_q;

  state_e                 state_q, state_d;
  ipos_t                  lo_q, lo_d;
  ipos_t                  hi_q, hi_d;
  ipos_t                  end_q, end_d;
  ipos_t                  mid_q, mid_d;
  ipos_t                  ub_q, ub_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic                   found_q, found_d;
  logic                   oor_q, oor_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_found_q, out_found_d;
  logic [PosW-1:0]        out_pos_q, out_pos_d;
  logic [PosW-1:0]        out_ub_q, out_ub_d;

  logic                   in_acc;
  logic                   mem_we, mem_re;
  logic [AddrW-1:0]       mem_waddr, mem_raddr;
  logic [PosW-1:0]        rd_pos;
  logic signed [IntW:0]   mid_sum;
  logic signed [KeyW-1:0] probe_key;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;

  // Positions at or past the store depth read as zero.
  assign probe_key = oor_q ? '0 : rdata_q;
  // Inside the loop both bounds are non-negative, so the shift is the
  // truncating halve.
  assign mid_sum   = {lo_q[IntW-1], lo_q} + {hi_q[IntW-1], hi_q};

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    end_d       = end_q;
    mid_d       = mid_q;
    ub_d        = ub_q;
    key_d       = key_q;
    found_d     = found_q;
    oor_d       = oor_q;
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    out_ub_d    = out_ub_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    rd_pos      = '0;

    // Drain the result register.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (action_i == ActWrite) begin
            // Drop writes past the store depth.
            mem_we = (32'(write_index_i) < 32'(STORE_DEPTH));
          end else begin
            lo_d    = ipos_t'({1'b0, range_low_i});
            hi_d    = ipos_t'(range_high_i);
            end_d   = ipos_t'(range_high_i);
            key_d   = key_value_i;
            found_d = 1'b0;
            state_d = StSearch;
          end
        end
      end
      StSearch: begin
        if (lo_q <= hi_q) begin
          mid_d   = mid_sum[IntW:1];
          rd_pos  = mid_sum[PosW:1];
          mem_re  = 1'b1;
          oor_d   = (32'(rd_pos) >= 32'(STORE_DEPTH));
          state_d = StProbe;
        end else begin
          // Range exhausted or empty: hi is the last smaller position.
          ub_d    = hi_q + ipos_t'(1);
          state_d = StDone;
        end
      end
      StProbe: begin
        if (probe_key < key_q) begin
          lo_d    = mid_q + ipos_t'(1);
          state_d = StSearch;
        end else if (probe_key > key_q) begin
          hi_d    = mid_q - ipos_t'(1);
          state_d = StSearch;
        end else begin
          found_d = 1'b1;
          hi_d    = mid_q;
          ub_d    = mid_q + ipos_t'(1);
          state_d = StScan;
        end
      end
      StScan: begin
        if (ub_q <= end_q) begin
          rd_pos  = ub_q[PosW-1:0];
          mem_re  = 1'b1;
          oor_d   = (32'(rd_pos) >= 32'(STORE_DEPTH));
          state_d = StScanCmp;
        end else begin
          state_d = StDone;
        end
      end
      StScanCmp: begin
        if (probe_key == key_q) begin
          ub_d    = ub_q + ipos_t'(1);
          state_d = StScan;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Hold until the result register is free or draining.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          out_pos_d   = hi_q[PosW-1:0];
          out_ub_d    = ub_q[PosW-1:0];
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    mem_waddr = AddrW'(write_index_i);
    mem_raddr = AddrW'(rd_pos);
  end

  // Key memory: one write or one read per cycle, registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= key_value_i;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    end_q       <= end_d;
    mid_q       <= mid_d;
    ub_q        <= ub_d;
    key_q       <= key_d;
    oor_q       <= oor_d;
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
    out_ub_q    <= out_ub_d;
  end

  assign out_valid_o            = out_valid_q;
  assign match_found_o          = out_found_q;
  assign match_position_o       = out_pos_q;
  assign upper_bound_position_o = out_ub_q;

endmodule

[rtl/skubs_checker.sv]
// ----------------------------------------------------------------------------
// skubs_checker
// Port-level checks for the sorted-key search block, bound to the top level.
// ----------------------------------------------------------------------------
module skubs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                action_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                match_found_o,
  input logic signed [skubs_pkg::PosW-1:0]   match_position_o,
  input logic [skubs_pkg::PosW-1:0]          upper_bound_position_o
);
  import skubs_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_found_o)
      && $stable(match_position_o) && $stable(upper_bound_position_o))
    else $error("result changed while stalled");

  // A query transaction keeps the input side busy for the next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ActQuery) |=> !in_ready_o)
    else $error("input ready right after a query");

  // A write transaction leaves the input side ready in the next cycle.
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ActWrite) |=> in_ready_o)
    else $error("input not ready after a write");

  // Without a match the upper bound follows the last smaller position.
  a_miss_ub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !match_found_o |->
      upper_bound_position_o == PosW'(match_position_o + PosW'(1)))
    else $error("miss upper bound mismatch");

  // A match lies at a real position and the upper bound lies past it.
  a_hit_ub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_found_o |->
      !match_position_o[PosW-1] && (upper_bound_position_o > match_position_o))
    else $error("hit upper bound not past the match");

endmodule

bind sorted_key_upper_bound_search skubs_checker u_skubs_checker (.*);
